@@ src/ps2kb_pkg.sv @@
// types, constants and helpers shared by the ps2 key buffer modules
`timescale 1ns / 1ps

package ps2kb_pkg;

  localparam int RingDepth = 16;
  localparam int RingAw    = (RingDepth > 1) ? $clog2(RingDepth) : 1;

  localparam logic [7:0] ScanExt    = 8'hE0;
  localparam logic [7:0] ScanBreak  = 8'hF0;
  localparam logic [8:0] ReleaseBit = 9'h100;
  localparam logic [8:0] ExtOffset  = 9'd128;

  typedef logic [8:0] key_word_t;
  typedef logic [RingAw-1:0] ring_ptr_t;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhBreak = 2'd1,
    PhExt   = 2'd2
  } phase_e;

  typedef enum logic {
    ActScan = 1'b0,
    ActRead = 1'b1
  } action_e;

  // completed word from the decoder
  typedef struct packed {
    logic      valid;
    key_word_t word;
  } push_t;

  // registered ring read result
  typedef struct packed {
    logic      empty;
    key_word_t word;
  } ring_rd_t;

  // result word, lowest field in the lowest bit
  typedef struct packed {
    logic [7:0] code;
    logic       released;
    logic       present;
  } key_out_t;

  function automatic ring_ptr_t ring_next(input ring_ptr_t p);
    ring_ptr_t r;
    if (p == ring_ptr_t'(RingDepth - 1)) begin
      r = '0;
    end else begin
      r = p + ring_ptr_t'(1);
    end
    return r;
  endfunction

endpackage

@@ src/ps2kb_decoder.sv @@
// set-2 prefix decoder that assembles key words from scan bytes
`timescale 1ns / 1ps

module ps2kb_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  input  logic [7:0]     scan_byte_i,
  output ps2kb_pkg::push_t push_o
);
  import ps2kb_pkg::*;

  phase_e    phase_q, phase_d;
  key_word_t partial_q, partial_d;
  key_word_t ext_word;

  assign ext_word = {1'b0, scan_byte_i} + ExtOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      partial_q <= '0;
    end else begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    partial_d   = partial_q;
    push_o      = '0;
    if (byte_valid_i) begin
      case (phase_q)
        PhBreak: begin
          partial_d   = partial_q | {1'b0, scan_byte_i};
          push_o.valid = 1'b1;
          push_o.word  = partial_d;
          phase_d     = PhIdle;
        end
        PhExt: begin
          if (scan_byte_i == ScanBreak) begin
            partial_d = ReleaseBit;
          end else begin
            partial_d    = partial_q | ext_word;
            push_o.valid = 1'b1;
            push_o.word  = partial_d;
            phase_d      = PhIdle;
          end
        end
        default: begin
          if (scan_byte_i == ScanExt) begin
            partial_d = '0;
            phase_d   = PhExt;
          end else if (scan_byte_i == ScanBreak) begin
            partial_d = ReleaseBit;
            phase_d   = PhBreak;
          end else begin
            partial_d    = {1'b0, scan_byte_i};
            push_o.valid = 1'b1;
            push_o.word  = partial_d;
            phase_d      = PhIdle;
          end
        end
      endcase
    end
  end

endmodule

@@ src/ps2kb_ring.sv @@
// key ring memory with write and read pointers and a registered read port
`timescale 1ns / 1ps

module ps2kb_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ps2kb_pkg::push_t    push_i,
  input  logic                rd_req_i,
  output ps2kb_pkg::ring_rd_t rd_o
);
  import ps2kb_pkg::*;

  key_word_t mem [RingDepth];
  ring_ptr_t widx_q, widx_d;
  ring_ptr_t ridx_q, ridx_d;
  logic      empty;
  logic      empty_q;
  key_word_t rd_word_q;

  assign empty = (ridx_q == widx_q);

  always_comb begin
    widx_d = push_i.valid ? ring_next(widx_q) : widx_q;
    ridx_d = (rd_req_i && !empty) ? ring_next(ridx_q) : ridx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      ridx_q <= '0;
    end else begin
      widx_q <= widx_d;
      ridx_q <= ridx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[widx_q] <= push_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i) begin
      rd_word_q <= mem[ridx_q];
      empty_q   <= empty;
    end
  end

  assign rd_o.empty = empty_q;
  assign rd_o.word  = rd_word_q;

endmodule

@@ src/ps2_scan_code_key_buffer.sv @@
// ps2 scan code key buffer top level: decoder, key ring, repeat filter and output register
//
//  channel  | dir | handshake          | tuser         | tdata (lowest bit up)
//  ---------+-----+--------------------+---------------+-------------------------------------
//  s_axis   | in  | tvalid/tready      | action        | scan_byte[7:0]
//  m_axis   | out | tvalid/tready      | -             | key_present, key_released, key_code
//
//  one word per cycle in both directions while the output is taken
//  a read word gives its result via the ring read register, loaded at the accepting edge,
//  and then the filter output register, loaded once the output is free
//  scan words give no result; decoding and the ring write finish at the accepting edge
//  reset clears phase, pointers and last kept word; ring contents are not cleared
//  a stalled output fills the filter stage and then drops s_axis_tready
`timescale 1ns / 1ps

module ps2_scan_code_key_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // scan_byte[7:0]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // key_present, key_released, key_code[7:0], zero pad
);
  import ps2kb_pkg::*;

  logic      s_hs;
  logic      rd_req;
  push_t     push;
  ring_rd_t  rd;
  logic      s1_valid_q;
  logic      out_free;
  logic      s1_adv;
  logic      m_valid_q;
  key_out_t  out_q, out_d;
  key_word_t last_q, last_d;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign rd_req        = s_hs && (s_axis_tuser == ActRead);

  ps2kb_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_hs && (s_axis_tuser == ActScan)),
    .scan_byte_i  (s_axis_tdata),
    .push_o       (push)
  );

  ps2kb_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rd_req_i (rd_req),
    .rd_o     (rd)
  );

  // repeat filter and last kept word
  always_comb begin
    out_d  = '0;
    last_d = last_q;
    if (!rd.empty && (rd.word != last_q)) begin
      out_d.present  = 1'b1;
      out_d.released = rd.word[8];
      out_d.code     = rd.word[7:0];
      if (!(rd.word[8] && (rd.word[7:0] != last_q[7:0]))) begin
        last_d = rd.word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      last_q     <= '0;
    end else begin
      if (rd_req) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        m_valid_q <= 1'b1;
        last_q    <= last_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

  property p_stall_means_full;
    @(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> (s1_valid_q && m_valid_q);
  endproperty
  a_stall_means_full: assert property (p_stall_means_full)
    else $error("input stalled while a stage is free");

  property p_read_enters_stage;
    @(posedge clk_i) disable iff (!rst_ni)
      rd_req |=> s1_valid_q;
  endproperty
  a_read_enters_stage: assert property (p_read_enters_stage)
    else $error("accepted read not in filter stage");

  property p_last_only_on_advance;
    @(posedge clk_i) disable iff (!rst_ni)
      !s1_adv |=> $stable(last_q);
  endproperty
  a_last_only_on_advance: assert property (p_last_only_on_advance)
    else $error("last kept word changed without a filtered read");

  property p_absent_is_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_valid_q && !out_q.present) |-> (!out_q.released && (out_q.code == 8'd0));
  endproperty
  a_absent_is_zero: assert property (p_absent_is_zero)
    else $error("empty result carries key data");

endmodule
